// File: rtl/tfn_pkg.sv
// Shared types, widths and helpers for the triangle face normal line block.
package tfn_pkg;

   localparam int CoordW = 24;
   localparam int LenW   = 23;
   localparam int EdgeW  = 25;
   localparam int SumW3  = 26;
   localparam int ProdW  = 50;
   localparam int MagW   = 50;
   localparam int TopW   = 6;
   localparam int NormW  = 31;
   localparam int SqW    = 62;
   localparam int RadW   = 64;
   localparam int RootW  = 32;
   localparam int MulW   = 54;
   localparam int NumW   = 55;
   localparam int QuotW  = 24;

   localparam int NormTop = 30;
   localparam logic [LenW-1:0] LenReset = 23'd19661;
   // floor(x/3) = (x * Recip3) >> 33 for any 32-bit x
   localparam logic [31:0] Recip3 = 32'hAAAA_AAAB;

   typedef struct packed {
      logic signed [CoordW-1:0] a_x;
      logic signed [CoordW-1:0] a_y;
      logic signed [CoordW-1:0] a_z;
      logic signed [CoordW-1:0] b_x;
      logic signed [CoordW-1:0] b_y;
      logic signed [CoordW-1:0] b_z;
      logic signed [CoordW-1:0] c_x;
      logic signed [CoordW-1:0] c_y;
      logic signed [CoordW-1:0] c_z;
   } tfn_req_type;

   typedef struct packed {
      logic signed [CoordW-1:0] mid_x;
      logic signed [CoordW-1:0] mid_y;
      logic signed [CoordW-1:0] mid_z;
      logic signed [CoordW-1:0] end_x;
      logic signed [CoordW-1:0] end_y;
      logic signed [CoordW-1:0] end_z;
      logic                     degenerate;
   } tfn_rsp_type;

   // per-item data that rides alongside the root and divide pipes
   typedef struct packed {
      logic [2:0][NormW-1:0]  mag;
      logic [2:0]             neg;
      logic [2:0][CoordW-1:0] mid;
      logic                   degen;
   } tfn_side_type;

   function automatic logic signed [CoordW-1:0] sat24(input logic signed [SumW3-1:0] v);
      logic signed [SumW3-1:0] hi;
      logic signed [SumW3-1:0] lo;
      hi = SumW3'(signed'({1'b0, {(CoordW-1){1'b1}}}));
      lo = -hi - SumW3'(1);
      if (v > hi) begin
         return hi[CoordW-1:0];
      end else if (v < lo) begin
         return lo[CoordW-1:0];
      end
      return v[CoordW-1:0];
   endfunction

endpackage

// File: rtl/tfn_chan_if.sv
// Valid/ready channel interface carrying one payload per transfer.
interface tfn_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/triangle_face_normal_line.sv
// Top level: triangle centroid and face normal line end point, fully pipelined.
//
// Use:
//   req_bus  - one triangle per transfer (three vertices, signed Q8.16).
//   rsp_bus  - one result per triangle, in order: centroid, end point of the
//              normal line, degenerate flag.
//   csr_bus  - writes the normal line length (unsigned Q7.16). Always ready;
//              write only while no triangle is in flight.
// Pipeline: 7 front stages, 32 square-root stages, 26 divide stages, one
//   output register.
// Throughput: one triangle per cycle while the pipe is not frozen; the 32-stage
//   square root and the 24-stage divide each retire one bit per stage, so nothing iterates.
// Stall: the whole pipe advances on one enable. Behind the output register
//   sits a one-entry skid register; while it is empty the pipe keeps moving
//   and req_ready stays high, so one more transfer is taken while a result
//   waits. Once the skid holds a result the pipe freezes, valid bits and all,
//   and req_ready drops until rsp_ready drains it.
// Reset: clears every stage valid and the output and skid valid bits, and sets
//   the line length to its default of about 0.3.
// Degenerate triangles (zero cross product) report the centroid as end point.
module triangle_face_normal_line import tfn_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   tfn_chan_if.sink   req_bus,
   tfn_chan_if.source rsp_bus,
   tfn_chan_if.sink   csr_bus
);

   // line length register
   logic [LenW-1:0] len_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LenReset;
      end else if (csr_bus.valid) begin
         len_ff <= csr_bus.data;
      end
   end

   // global advance: pipe moves whenever the skid slot is free
   logic out_v_ff;
   logic skid_v_ff;
   tfn_rsp_type out_ff;
   tfn_rsp_type skid_ff;
   logic en;

   assign en            = !skid_v_ff;
   assign req_bus.ready = en;

   // front: edges, centroid, cross product, normalize, squared length
   logic            fr_valid;
   logic [RadW-1:0] fr_rad;
   tfn_side_type    fr_side;

   tfn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_bus.valid),
      .in_data   (req_bus.data),
      .out_valid (fr_valid),
      .out_rad   (fr_rad),
      .out_side  (fr_side)
   );

   // length of the normalized cross product
   logic             sq_valid;
   logic [RootW-1:0] sq_root;
   tfn_side_type     sq_side;

   tfn_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_rad    (fr_rad),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // offset magnitudes per axis
   logic                  dv_valid;
   logic [2:0][QuotW-1:0] dv_quot;
   tfn_side_type          dv_side;

   tfn_div u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .line_length (len_ff),
      .in_valid    (sq_valid),
      .in_root     (sq_root),
      .in_side     (sq_side),
      .out_valid   (dv_valid),
      .out_quot    (dv_quot),
      .out_side    (dv_side)
   );

   // apply sign, add to centroid, saturate
   tfn_rsp_type fin;
   logic signed [CoordW-1:0] mid_s [3];
   logic signed [CoordW-1:0] end_s [3];
   logic signed [EdgeW-1:0]  off_s;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mid_s[i] = $signed(dv_side.mid[i]);
         off_s    = $signed({1'b0, dv_quot[i]});
         if (dv_side.neg[i]) begin
            off_s = -off_s;
         end
         if (dv_side.degen) begin
            end_s[i] = mid_s[i];
         end else begin
            end_s[i] = sat24(SumW3'(mid_s[i]) + SumW3'(off_s));
         end
      end
      fin.mid_x      = mid_s[0];
      fin.mid_y      = mid_s[1];
      fin.mid_z      = mid_s[2];
      fin.end_x      = end_s[0];
      fin.end_y      = end_s[1];
      fin.end_z      = end_s[2];
      fin.degenerate = dv_side.degen;
   end

   // output register plus skid slot
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         // pipe frozen; drain skid into output once the current one leaves
         if (rsp_bus.ready) begin
            out_ff    <= skid_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (!out_v_ff || rsp_bus.ready) begin
         out_v_ff <= dv_valid;
         if (dv_valid) begin
            out_ff <= fin;
         end
      end else if (dv_valid) begin
         skid_ff   <= fin;
         skid_v_ff <= 1'b1;
      end
   end

   assign rsp_bus.valid = out_v_ff;
   assign rsp_bus.data  = out_ff;

endmodule

// File: rtl/tfn_front.sv
// Front pipe: edges, centroid, cross product, normalize shift, squared length.
module tfn_front import tfn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  tfn_req_type  in_data,
   output logic         out_valid,
   output logic [RadW-1:0] out_rad,
   output tfn_side_type out_side
);

   logic [6:0] v_ff;

   // stage 1
   logic signed [EdgeW-1:0] e1_ff [3];
   logic signed [EdgeW-1:0] e2_ff [3];
   logic signed [SumW3-1:0] tot_ff [3];
   // stage 2
   logic signed [ProdW-1:0] p_ff [6];
   logic [CoordW-1:0]       q3_ff [3];
   logic [2:0]              tneg_ff;
   // stage 3
   logic [2:0][MagW-1:0]    mag3_ff;
   logic [2:0]              neg3_ff;
   logic [2:0][CoordW-1:0]  mid3_ff;
   // stage 4
   logic [2:0][MagW-1:0]    mag4_ff;
   logic [2:0]              neg4_ff;
   logic [2:0][CoordW-1:0]  mid4_ff;
   logic [TopW-1:0]         top_ff;
   logic                    degen4_ff;
   // stage 5
   tfn_side_type            side5_ff;
   // stage 6
   logic [SqW-1:0]          sq_ff [3];
   tfn_side_type            side6_ff;
   // stage 7
   logic [RadW-1:0]         rad_ff;
   tfn_side_type            side7_ff;

   logic signed [CoordW-1:0] a [3];
   logic signed [CoordW-1:0] b [3];
   logic signed [CoordW-1:0] c [3];

   assign a[0] = in_data.a_x;
   assign a[1] = in_data.a_y;
   assign a[2] = in_data.a_z;
   assign b[0] = in_data.b_x;
   assign b[1] = in_data.b_y;
   assign b[2] = in_data.b_z;
   assign c[0] = in_data.c_x;
   assign c[1] = in_data.c_y;
   assign c[2] = in_data.c_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   // stage 1: edges and coordinate sums
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i]  <= EdgeW'(b[i]) - EdgeW'(a[i]);
            e2_ff[i]  <= EdgeW'(c[i]) - EdgeW'(a[i]);
            tot_ff[i] <= SumW3'(a[i]) + SumW3'(b[i]) + SumW3'(c[i]);
         end
      end
   end

   // stage 2: cross products and divide by three (rounded magnitude)
   logic [EdgeW-1:0] tabs [3];
   logic [31:0]      tx [3];
   logic [63:0]      tp [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tabs[i] = tot_ff[i][SumW3-1] ? EdgeW'(-tot_ff[i]) : EdgeW'(tot_ff[i]);
         tx[i]   = 32'(tabs[i]) + 32'd1;
         tp[i]   = {32'b0, tx[i]} * {32'b0, Recip3};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= e1_ff[1] * e2_ff[2];
         p_ff[1] <= e1_ff[2] * e2_ff[1];
         p_ff[2] <= e1_ff[2] * e2_ff[0];
         p_ff[3] <= e1_ff[0] * e2_ff[2];
         p_ff[4] <= e1_ff[0] * e2_ff[1];
         p_ff[5] <= e1_ff[1] * e2_ff[0];
         for (int i = 0; i < 3; i++) begin
            q3_ff[i]   <= tp[i][56:33];
            tneg_ff[i] <= tot_ff[i][SumW3-1];
         end
      end
   end

   // stage 3: components to sign and magnitude, signed centroid
   logic signed [ProdW:0] n [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n[i] = (ProdW+1)'(p_ff[2*i]) - (ProdW+1)'(p_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            neg3_ff[i] <= n[i][ProdW];
            mag3_ff[i] <= n[i][ProdW] ? MagW'(-n[i]) : MagW'(n[i]);
            mid3_ff[i] <= tneg_ff[i] ? -q3_ff[i] : q3_ff[i];
         end
      end
   end

   // stage 4: leading one of the largest magnitude
   logic [MagW-1:0] orv;
   logic [TopW-1:0] top_in;
   always_comb begin
      orv    = mag3_ff[0] | mag3_ff[1] | mag3_ff[2];
      top_in = '0;
      for (int j = 0; j < MagW; j++) begin
         if (orv[j]) begin
            top_in = TopW'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag4_ff   <= mag3_ff;
         neg4_ff   <= neg3_ff;
         mid4_ff   <= mid3_ff;
         top_ff    <= top_in;
         degen4_ff <= (orv == '0);
      end
   end

   // stage 5: common shift so the largest lands in [2^30, 2^31)
   tfn_side_type side5_in;
   logic [TopW-1:0] sh_r;
   logic [TopW-1:0] sh_l;
   always_comb begin
      sh_r = top_ff - TopW'(NormTop);
      sh_l = TopW'(NormTop) - top_ff;
      side5_in.neg   = neg4_ff;
      side5_in.mid   = mid4_ff;
      side5_in.degen = degen4_ff;
      for (int i = 0; i < 3; i++) begin
         if (top_ff > TopW'(NormTop)) begin
            side5_in.mag[i] = NormW'(mag4_ff[i] >> sh_r);
         end else begin
            side5_in.mag[i] = NormW'(mag4_ff[i] << sh_l);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side5_ff <= side5_in;
      end
   end

   // stage 6: squares
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= SqW'(side5_ff.mag[i]) * SqW'(side5_ff.mag[i]);
         end
         side6_ff <= side5_ff;
      end
   end

   // stage 7: sum of squares
   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff   <= RadW'(sq_ff[0]) + RadW'(sq_ff[1]) + RadW'(sq_ff[2]);
         side7_ff <= side6_ff;
      end
   end

   assign out_valid = v_ff[6];
   assign out_rad   = rad_ff;
   assign out_side  = side7_ff;

endmodule

// File: rtl/tfn_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module tfn_isqrt import tfn_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [RadW-1:0]  in_rad,
   input  tfn_side_type     in_side,
   output logic             out_valid,
   output logic [RootW-1:0] out_root,
   output tfn_side_type     out_side
);

   logic [RadW-1:0]  rem_w  [RootW+1];
   logic [RootW-1:0] root_w [RootW+1];
   logic             v_w    [RootW+1];
   tfn_side_type     side_w [RootW+1];

   assign rem_w[0]  = in_rad;
   assign root_w[0] = '0;
   assign v_w[0]    = in_valid;
   assign side_w[0] = in_side;

   for (genvar k = 0; k < RootW; k++) begin : g_stage
      localparam int Bit = RootW - 1 - k;

      logic [RadW+1:0]  trial;
      logic             take;
      logic [RadW-1:0]  rem_in;
      logic [RootW-1:0] root_in;
      logic [RadW-1:0]  rem_ff;
      logic [RootW-1:0] root_ff;
      logic             v_ff;
      tfn_side_type     side_ff;

      always_comb begin
         trial   = ((RadW+2)'(root_w[k]) << (Bit + 1)) | ((RadW+2)'(1) << (2 * Bit));
         take    = (RadW+2)'(rem_w[k]) >= trial;
         rem_in  = take ? rem_w[k] - trial[RadW-1:0] : rem_w[k];
         root_in = take ? root_w[k] | (RootW'(1) << Bit) : root_w[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= v_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            side_ff <= side_w[k];
         end
      end

      assign rem_w[k+1]  = rem_ff;
      assign root_w[k+1] = root_ff;
      assign v_w[k+1]    = v_ff;
      assign side_w[k+1] = side_ff;
   end

   assign out_valid = v_w[RootW];
   assign out_root  = root_w[RootW];
   assign out_side  = side_w[RootW];

endmodule

// File: rtl/tfn_div.sv
// Three-lane pipelined rounding divide: (mag * length + root/2) / root.
module tfn_div import tfn_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic [LenW-1:0]         line_length,
   input  logic                    in_valid,
   input  logic [RootW-1:0]        in_root,
   input  tfn_side_type            in_side,
   output logic                    out_valid,
   output logic [2:0][QuotW-1:0]   out_quot,
   output tfn_side_type            out_side
);

   logic [1:0]            va_ff;
   logic [2:0][MulW-1:0]  prod_ff;
   logic [RootW-1:0]      roota_ff;
   tfn_side_type          sidea_ff;
   logic [2:0][NumW-1:0]  num_ff;
   logic [RootW-1:0]      rootb_ff;
   tfn_side_type          sideb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= '0;
      end else if (en) begin
         va_ff <= {va_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= MulW'(in_side.mag[i]) * MulW'(line_length);
            num_ff[i]  <= NumW'(prod_ff[i]) + NumW'(roota_ff >> 1);
         end
         roota_ff <= in_root;
         sidea_ff <= in_side;
         rootb_ff <= roota_ff;
         sideb_ff <= sidea_ff;
      end
   end

   logic [2:0][NumW-1:0]  rem_w  [QuotW+1];
   logic [2:0][QuotW-1:0] quot_w [QuotW+1];
   logic [RootW-1:0]      root_w [QuotW+1];
   logic                  v_w    [QuotW+1];
   tfn_side_type          side_w [QuotW+1];

   assign rem_w[0]  = num_ff;
   assign quot_w[0] = '0;
   assign root_w[0] = rootb_ff;
   assign v_w[0]    = va_ff[1];
   assign side_w[0] = sideb_ff;

   for (genvar k = 0; k < QuotW; k++) begin : g_stage
      localparam int Bit = QuotW - 1 - k;

      logic [NumW-1:0]       den;
      logic [2:0][NumW-1:0]  rem_in;
      logic [2:0][QuotW-1:0] quot_in;
      logic [2:0][NumW-1:0]  rem_ff;
      logic [2:0][QuotW-1:0] quot_ff;
      logic [RootW-1:0]      root_ff;
      logic                  v_ff;
      tfn_side_type          side_ff;

      always_comb begin
         den = NumW'(root_w[k]) << Bit;
         for (int i = 0; i < 3; i++) begin
            if (rem_w[k][i] >= den) begin
               rem_in[i]  = rem_w[k][i] - den;
               quot_in[i] = quot_w[k][i] | (QuotW'(1) << Bit);
            end else begin
               rem_in[i]  = rem_w[k][i];
               quot_in[i] = quot_w[k][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= v_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            quot_ff <= quot_in;
            root_ff <= root_w[k];
            side_ff <= side_w[k];
         end
      end

      assign rem_w[k+1]  = rem_ff;
      assign quot_w[k+1] = quot_ff;
      assign root_w[k+1] = root_ff;
      assign v_w[k+1]    = v_ff;
      assign side_w[k+1] = side_ff;
   end

   assign out_valid = v_w[QuotW];
   assign out_quot  = quot_w[QuotW];
   assign out_side  = side_w[QuotW];

endmodule

// File: rtl/tfn_checker.sv
// Port-level checks for the triangle face normal line block, bound to the top.
module tfn_checker import tfn_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input tfn_rsp_type rsp_data
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // degenerate triangles end at the centroid
   a_degen_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.end_x == rsp_data.mid_x && rsp_data.end_y == rsp_data.mid_y &&
         rsp_data.end_z == rsp_data.mid_z)
      else $error("degenerate result with end point off the centroid");

   // with an empty output the input side never blocks
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked while output is empty");

   // reset empties the output
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind triangle_face_normal_line tfn_checker u_tfn_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  (rsp_bus.data)
);
